>>> rtl/usb_ep0_setup_responder_core_assert.svh
// assertion macros for the endpoint 0 responder
`ifndef USB_EP0_SETUP_RESPONDER_CORE_ASSERT_SVH
`define USB_EP0_SETUP_RESPONDER_CORE_ASSERT_SVH

// property must hold whenever out of reset
`define EP0_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication from one cycle to the next
`define EP0_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ep0_pkg.sv
// shared types and constants for the endpoint 0 responder
package ep0_pkg;

    localparam logic [1:0] CMD_SETUP   = 2'd0;
    localparam logic [1:0] CMD_IN_DONE = 2'd1;

    localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
    localparam logic [7:0] REQ_GET_DESC    = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE    = 8'h0A;

    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_STRING = 8'h03;
    localparam logic [7:0] DT_REPORT = 8'h22;

    localparam logic [7:0] OFS_DEV  = 8'd0;
    localparam logic [7:0] LEN_DEV  = 8'd18;
    localparam logic [7:0] OFS_CFG  = 8'd18;
    localparam logic [7:0] LEN_CFG  = 8'd41;
    localparam logic [7:0] OFS_RPT  = 8'd59;
    localparam logic [7:0] LEN_RPT  = 8'd27;
    localparam logic [7:0] OFS_LANG = 8'd86;
    localparam logic [7:0] LEN_LANG = 8'd4;
    localparam logic [7:0] OFS_MANU = 8'd90;
    localparam logic [7:0] LEN_MANU = 8'd18;
    localparam logic [7:0] OFS_PROD = 8'd108;
    localparam logic [7:0] LEN_PROD = 8'd10;
    localparam logic [7:0] OFS_SER  = 8'd118;
    localparam logic [7:0] LEN_SER  = 8'd22;
    localparam int unsigned ROM_SIZE = 140;

    localparam logic [1:0] REG_RPT_SIZE  = 2'd0;
    localparam logic [1:0] REG_VENDOR_ID = 2'd1;
    localparam logic [1:0] REG_PRODUCT_ID = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_WB
    } t_state;

    // transfer context held in the state memory
    typedef struct packed {
        logic [5:0] bytes_remaining;
        logic [7:0] rom_position;
        logic       zero_pending;
        logic [7:0] config_value;
    } t_ctx;

    localparam int unsigned CTX_W = $bits(t_ctx);

    // side-action flags carried on every byte of a packet
    typedef struct packed {
        logic       set_address;
        logic [6:0] device_address;
        logic       set_endpoints;
    } t_side;

    // static descriptor bytes, patched ones handled in the rom module
    function automatic logic [7:0] desc_byte(input logic [7:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case (pos)
            8'd0: b = 8'h12; 8'd1: b = 8'h01; 8'd2: b = 8'h10; 8'd3: b = 8'h01;
            8'd13: b = 8'h01; 8'd14: b = 8'h01; 8'd15: b = 8'h02;
            8'd16: b = 8'h03; 8'd17: b = 8'h01;
            8'd18: b = 8'h09; 8'd19: b = 8'h02; 8'd20: b = 8'h29;
            8'd22: b = 8'h01; 8'd23: b = 8'h01; 8'd25: b = 8'h80; 8'd26: b = 8'hFA;
            8'd27: b = 8'h09; 8'd28: b = 8'h04; 8'd31: b = 8'h02; 8'd32: b = 8'h03;
            8'd36: b = 8'h09; 8'd37: b = 8'h21; 8'd38: b = 8'h10; 8'd39: b = 8'h01;
            8'd40: b = 8'h21; 8'd41: b = 8'h01; 8'd42: b = 8'h22; 8'd43: b = 8'h1B;
            8'd45: b = 8'h07; 8'd46: b = 8'h05; 8'd47: b = 8'h81; 8'd48: b = 8'h03;
            8'd49: b = 8'h10; 8'd51: b = 8'h01;
            8'd52: b = 8'h07; 8'd53: b = 8'h05; 8'd54: b = 8'h01; 8'd55: b = 8'h03;
            8'd56: b = 8'h10; 8'd58: b = 8'h01;
            8'd59: b = 8'h05; 8'd60: b = 8'h01; 8'd61: b = 8'h09; 8'd63: b = 8'hA1;
            8'd64: b = 8'h01; 8'd65: b = 8'h15; 8'd67: b = 8'h25; 8'd68: b = 8'hFF;
            8'd69: b = 8'h19; 8'd70: b = 8'h01; 8'd71: b = 8'h29; 8'd73: b = 8'h95;
            8'd75: b = 8'h75; 8'd76: b = 8'h08; 8'd77: b = 8'h81; 8'd78: b = 8'h02;
            8'd79: b = 8'h19; 8'd80: b = 8'h01; 8'd81: b = 8'h29; 8'd83: b = 8'h91;
            8'd84: b = 8'h02; 8'd85: b = 8'hC0;
            8'd86: b = 8'h04; 8'd87: b = 8'h03; 8'd88: b = 8'h09; 8'd89: b = 8'h04;
            8'd90: b = 8'h12; 8'd91: b = 8'h03; 8'd92: b = 8'h7A; 8'd93: b = 8'h66;
            8'd94: b = 8'hFD; 8'd95: b = 8'h80; 8'd96: b = 8'hFA; 8'd97: b = 8'h5E;
            8'd98: b = 8'h51; 8'd99: b = 8'h7B; 8'd100: b = 8'h35; 8'd101: b = 8'h75;
            8'd102: b = 8'h14; 8'd103: b = 8'h6C; 8'd104: b = 8'hD1; 8'd105: b = 8'h76;
            8'd106: b = 8'hA7; 8'd107: b = 8'h63;
            8'd108: b = 8'h0A; 8'd109: b = 8'h03; 8'd110: b = 8'h51; 8'd111: b = 8'h7F;
            8'd112: b = 8'h73; 8'd113: b = 8'h51; 8'd114: b = 8'h21; 8'd115: b = 8'h6A;
            8'd116: b = 8'h57; 8'd117: b = 8'h57;
            8'd118: b = 8'h16; 8'd119: b = 8'h03; 8'd120: b = 8'h32; 8'd122: b = 8'h30;
            8'd124: b = 8'h31; 8'd126: b = 8'h33; 8'd128: b = 8'h2E; 8'd130: b = 8'h31;
            8'd132: b = 8'h31; 8'd134: b = 8'h2E; 8'd136: b = 8'h32; 8'd138: b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/ep0_ram.sv
// generic simple dual-port ram with registered read
module ep0_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/ep0_rom.sv
// descriptor rom with configured bytes patched in, registered read
module ep0_rom import ep0_pkg::*; #(
    parameter int unsigned MAX_PACKET = 16
) (
    input  logic        i_clk,
    input  logic [7:0]  i_addr,
    input  logic [4:0]  i_rpt_size,
    input  logic [15:0] i_vendor_id,
    input  logic [15:0] i_product_id,
    output logic [7:0]  o_data
);
    logic [7:0] n_data;
    logic [7:0] r_data;

    // patch table bytes that follow configuration
    always_comb begin
        n_data = desc_byte(i_addr);
        if (i_addr == OFS_DEV + 8'd7) begin
            n_data = 8'(MAX_PACKET);
        end else if (i_addr == OFS_DEV + 8'd8) begin
            n_data = i_vendor_id[7:0];
        end else if (i_addr == OFS_DEV + 8'd9) begin
            n_data = i_vendor_id[15:8];
        end else if (i_addr == OFS_DEV + 8'd10) begin
            n_data = i_product_id[7:0];
        end else if (i_addr == OFS_DEV + 8'd11) begin
            n_data = i_product_id[15:8];
        end else if (i_addr == OFS_RPT + 8'd13 || i_addr == OFS_RPT + 8'd15
                     || i_addr == OFS_RPT + 8'd23) begin
            n_data = {3'b000, i_rpt_size};
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

>>> rtl/usb_ep0_setup_responder_core.sv
// top level of the endpoint 0 responder
//
// channel   dir  fields
// s_axis    in   command, request_type/code/value/index/length
// m_axis    out  data_byte, flags, side actions (one transfer per byte)
// apb       in   rpt_size, vendor_id, product_id
//
// one item: accept, one context memory read, then n bytes one per cycle while
// m_axis is ready, from the descriptor rom (n up to MAX_PACKET, one for a
// zero-length packet), then write back; other commands skip emit and write back.
// reset is synchronous; it clears the context memory through its valid bit.
// a stalled output holds the sequencer; input is taken only when idle.
`include "usb_ep0_setup_responder_core_assert.svh"
module usb_ep0_setup_responder_core import ep0_pkg::*; #(
    parameter int unsigned MAX_PACKET = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], request_type[9:2], request_code[17:10], request_value[33:18],
    // request_index[49:34], request_length[65:50], zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // packet_empty[0], set_address[1], device_address[8:2], set_endpoints[9],
    // endpoints_enabled[10]
    output logic [10:0] m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned CW = $clog2(MAX_PACKET + 1);

    t_state r_state, n_state;
    logic [4:0]  r_rpt_size;
    logic [15:0] r_vendor_id, r_product_id;
    logic [1:0]  reg_idx;

    // config registers
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpt_size   <= 5'd11;
            r_vendor_id  <= 16'd34952;
            r_product_id <= 16'd6;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_RPT_SIZE:   r_rpt_size   <= pwdata[4:0];
                REG_VENDOR_ID:  r_vendor_id  <= pwdata[15:0];
                REG_PRODUCT_ID: r_product_id <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (reg_idx)
            REG_RPT_SIZE:   prdata = {27'd0, r_rpt_size};
            REG_VENDOR_ID:  prdata = {16'd0, r_vendor_id};
            REG_PRODUCT_ID: prdata = {16'd0, r_product_id};
            default:        prdata = 32'd0;
        endcase
    end

    // latched input item
    logic [1:0]  r_cmd;
    logic [7:0]  r_rtype, r_code;
    logic [15:0] r_wval, r_wlen;
    logic        in_xfer;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd   <= s_axis_tdata[1:0];
            r_rtype <= s_axis_tdata[9:2];
            r_code  <= s_axis_tdata[17:10];
            r_wval  <= s_axis_tdata[33:18];
            r_wlen  <= s_axis_tdata[65:50];
        end
    end

    // context memory, two entries with only entry 0 used; valid bit stands in for reset values
    t_ctx mem_rd, ctx_rd, r_ctx, wb_ctx;
    logic r_mem_valid;
    logic mem_we;
    ep0_ram #(.WIDTH(CTX_W), .DEPTH(2)) u_ctx_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(1'b0),
        .i_wdata(wb_ctx),
        .i_raddr(1'b0),
        .o_rdata(mem_rd)
    );
    assign ctx_rd = r_mem_valid ? mem_rd : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= 1'b0;
        end else if (mem_we) begin
            r_mem_valid <= 1'b1;
        end
    end

    // decode the item against the read context
    t_ctx   dec_ctx;
    t_side  dec_side;
    logic   [7:0] d_ofs, d_len;
    logic   d_desc;
    logic   [1:0] kind;
    always_comb begin
        dec_ctx  = ctx_rd;
        dec_side = '0;
        d_ofs = 8'd0;
        d_len = 8'd0;
        d_desc = 1'b0;
        kind = r_rtype[6:5];
        if (r_cmd == CMD_SETUP) begin
            dec_ctx.bytes_remaining = 6'd0;
            dec_ctx.zero_pending    = 1'b0;
            if (r_rtype[7]) begin
                if (kind == 2'd0 && r_code == REQ_GET_DESC) begin
                    case (r_wval[15:8])
                        DT_DEVICE: begin d_desc = 1'b1; d_ofs = OFS_DEV; d_len = LEN_DEV; end
                        DT_CONFIG: begin d_desc = 1'b1; d_ofs = OFS_CFG; d_len = LEN_CFG; end
                        DT_REPORT: begin d_desc = 1'b1; d_ofs = OFS_RPT; d_len = LEN_RPT; end
                        DT_STRING: begin
                            case (r_wval[7:0])
                                8'd0: begin d_desc = 1'b1; d_ofs = OFS_LANG; d_len = LEN_LANG; end
                                8'd1: begin d_desc = 1'b1; d_ofs = OFS_MANU; d_len = LEN_MANU; end
                                8'd2: begin d_desc = 1'b1; d_ofs = OFS_PROD; d_len = LEN_PROD; end
                                8'd3: begin d_desc = 1'b1; d_ofs = OFS_SER; d_len = LEN_SER; end
                                default: dec_ctx.zero_pending = 1'b1;
                            endcase
                        end
                        default: ;
                    endcase
                    if (d_desc) begin
                        dec_ctx.rom_position = d_ofs;
                        if (r_wlen > {8'd0, d_len}) begin
                            dec_ctx.bytes_remaining = d_len[5:0];
                            if (d_len[$clog2(MAX_PACKET)-1:0] == '0) begin
                                dec_ctx.zero_pending = 1'b1;
                            end
                        end else begin
                            dec_ctx.bytes_remaining = r_wlen[5:0];
                        end
                    end
                end
            end else if (kind == 2'd0 && r_code == REQ_SET_ADDRESS) begin
                dec_ctx.zero_pending    = 1'b1;
                dec_side.set_address    = 1'b1;
                dec_side.device_address = r_wval[6:0];
            end else if (kind == 2'd0 && r_code == REQ_SET_CONFIG) begin
                dec_ctx.config_value   = r_wval[7:0];
                dec_ctx.zero_pending   = 1'b1;
                dec_side.set_endpoints = 1'b1;
            end else if (kind == 2'd1 && r_code == REQ_SET_IDLE) begin
                dec_ctx.zero_pending = 1'b1;
            end
        end
    end

    // packet length and emptiness from the decoded context
    logic [CW-1:0] pkt_n;
    logic          pkt_empty;
    always_comb begin
        pkt_empty = 1'b0;
        if ({2'b00, dec_ctx.bytes_remaining} > 8'(MAX_PACKET)) begin
            pkt_n = CW'(MAX_PACKET);
        end else if (dec_ctx.bytes_remaining != 6'd0) begin
            pkt_n = CW'(dec_ctx.bytes_remaining);
        end else if (dec_ctx.zero_pending) begin
            pkt_n = CW'(1);
            pkt_empty = 1'b1;
        end else begin
            pkt_n = '0;
        end
    end

    // context to hold; a zero-length packet consumes its pending flag
    t_ctx ld_ctx;
    always_comb begin
        ld_ctx = dec_ctx;
        if (pkt_empty) begin
            ld_ctx.zero_pending = 1'b0;
        end
    end

    // emit counters
    t_side r_side;
    logic [CW-1:0] r_n, r_k;
    logic r_empty;
    logic out_xfer, emit_last, go;
    assign go = (r_cmd == CMD_SETUP || r_cmd == CMD_IN_DONE) && pkt_n != '0;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign emit_last = (r_k + CW'(1) == r_n);

    logic [7:0] rom_addr, rom_data;
    assign rom_addr = (r_state == ST_READ) ? dec_ctx.rom_position
                      : r_ctx.rom_position + 8'(r_k) + (out_xfer ? 8'd1 : 8'd0);
    ep0_rom #(.MAX_PACKET(MAX_PACKET)) u_rom (
        .i_clk       (i_clk),
        .i_addr      (rom_addr),
        .i_rpt_size  (r_rpt_size),
        .i_vendor_id (r_vendor_id),
        .i_product_id(r_product_id),
        .o_data      (rom_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_READ;
            ST_READ: begin
                if (r_cmd != CMD_SETUP && r_cmd != CMD_IN_DONE) n_state = ST_IDLE;
                else if (go) n_state = ST_EMIT;
                else n_state = ST_WB;
            end
            ST_EMIT: if (out_xfer && emit_last) n_state = ST_WB;
            ST_WB:   n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        mem_we = (r_state == ST_WB);
        m_axis_tvalid = (r_state == ST_EMIT);
        wb_ctx = r_ctx;
        if (!r_empty) begin
            wb_ctx.rom_position    = r_ctx.rom_position + 8'(r_n);
            wb_ctx.bytes_remaining = r_ctx.bytes_remaining - 6'(r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_READ) r_k <= '0;
            else if (out_xfer) r_k <= r_k + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_ctx   <= ld_ctx;
            r_side  <= dec_side;
            r_n     <= go ? pkt_n : '0;
            r_empty <= pkt_empty;
        end
    end

    // result payload
    assign m_axis_tdata = r_empty ? 8'd0
                          : ({1'b0, r_ctx.rom_position} + 9'(r_k) >= 9'(ROM_SIZE)
                             ? 8'd0 : rom_data);
    assign m_axis_tlast = emit_last;
    assign m_axis_tuser = {r_ctx.config_value != 8'd0, r_side.set_endpoints,
                           r_side.device_address, r_side.set_address, r_empty};

    `EP0_ASSERT(a_no_in_while_busy, i_clk, i_rst_n,
        !(s_axis_tready && m_axis_tvalid), "input ready while emitting")
    `EP0_ASSERT(a_empty_is_last, i_clk, i_rst_n,
        !(m_axis_tvalid && m_axis_tuser[0]) || m_axis_tlast, "empty packet not last")
    `EP0_ASSERT_NEXT(a_last_writes_back, i_clk, i_rst_n,
        out_xfer && m_axis_tlast, r_state == ST_WB, "no write back after packet")
endmodule
